>>> hw/rtl/b64e_pkg.sv
package b64e_pkg;

    localparam int GROUP_W = 24;
    localparam int SEXTET_W = 6;
    localparam int CHAR_W = 7;

    localparam logic [CHAR_W-1:0] PAD_CHAR = 7'd61;   // '='
    localparam logic [1:0] LAST_SLOT = 2'd3;

    // One encode job: the group left aligned (first sextet in the top bits),
    // the number of '=' characters that close it, and the end-of-message flag.
    typedef struct packed {
        logic [GROUP_W-1:0] group;
        logic [1:0]         pads;
        logic               eom;
    } job_t;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
    function automatic logic [CHAR_W-1:0] sextet_char(input logic [SEXTET_W-1:0] v);
        logic [CHAR_W-1:0] c;
        if (v < 6'd26) begin
            c = 7'd65 + {1'b0, v};
        end else if (v < 6'd52) begin
            c = 7'd71 + {1'b0, v};          // 'a' - 26
        end else if (v < 6'd62) begin
            c = {1'b0, v} - 7'd4;           // '0' - 52
        end else if (v == 6'd62) begin
            c = 7'd43;                      // '+'
        end else begin
            c = 7'd47;                      // '/'
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/b64e_channels.sv
interface b64e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64e_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

>>> hw/rtl/base64_stream_encoder.sv
// Base64 stream encoder, standard alphabet with '=' padding.
//
// raw   : input channel, one message byte per item (data_byte) with
//         end_of_message set on the last byte of a message.
// coded : output channel, one ASCII character per item (out_char), with
//         last_char set on the final character of the message.
// Every third byte, or the last byte of a message, completes a group that
// turns into exactly four characters; a short group ends in one or two '='.
//
// The byte that completes a group passes the job queue, the job register
// and the output register before the group's first character is offered.
// Throughput: one character per cycle out of the emitter while the
// receiver takes them, which sets the sustained rate; bytes that only
// fill a group are taken every cycle while the job queue has room.
// Reset clears the held bytes, the job queue and the output register.
// When the receiver stalls, the output item holds, the emitter stops, the
// queue fills up and then raw.ready drops until space frees.
module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    b64e_byte_if.sink   raw,
    b64e_char_if.source coded
);
    import b64e_pkg::*;

    job_t front_job;
    job_t queue_job;
    logic front_push;
    logic queue_ready;
    logic queue_valid;
    logic back_pop;

    // Group bytes and classify full or partial groups.
    b64e_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw       (raw),
        .job_ready (queue_ready),
        .job_push  (front_push),
        .job       (front_job)
    );

    // Decouple byte intake from character output.
    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_push),
        .push_job   (front_job),
        .push_ready (queue_ready),
        .pop        (back_pop),
        .pop_valid  (queue_valid),
        .pop_job    (queue_job)
    );

    // Emit four characters per job through the output register.
    b64e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (queue_valid),
        .job       (queue_job),
        .job_pop   (back_pop),
        .coded     (coded)
    );

endmodule

>>> hw/rtl/b64e_front.sv
module b64e_front (
    input  logic            clk,
    input  logic            rst_n,
    b64e_byte_if.sink       raw,
    input  logic            job_ready,
    output logic            job_push,
    output b64e_pkg::job_t  job
);
    import b64e_pkg::*;

    logic [15:0] pending_bits_reg;
    logic [15:0] pending_bits_next;
    logic [1:0]  pending_count_reg;
    logic [1:0]  pending_count_next;
    logic [1:0]  held;
    logic        accept;
    logic        emit;

    assign raw.ready = job_ready;
    assign accept    = raw.valid && job_ready;
    // A count of three never arises; treat it as nothing held.
    assign held      = (pending_count_reg == 2'd3) ? 2'd0 : pending_count_reg;
    assign emit      = (held == 2'd2) || raw.end_of_message;
    assign job_push  = accept && emit;

    always_comb
    begin
        job.eom = raw.end_of_message;
        unique case (held)
            2'd2:
            begin
                job.group = {pending_bits_reg, raw.data_byte};
                job.pads  = 2'd0;
            end
            2'd1:
            begin
                job.group = {pending_bits_reg[7:0], raw.data_byte, 8'd0};
                job.pads  = 2'd1;
            end
            default:
            begin
                job.group = {raw.data_byte, 16'd0};
                job.pads  = 2'd2;
            end
        endcase
    end

    always_comb
    begin
        pending_bits_next  = pending_bits_reg;
        pending_count_next = pending_count_reg;
        if (accept) begin
            if (emit) begin
                pending_bits_next  = '0;
                pending_count_next = '0;
            end else begin
                pending_bits_next  = {pending_bits_reg[7:0], raw.data_byte};
                pending_count_next = held + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pending_bits_reg  <= '0;
            pending_count_reg <= '0;
        end else begin
            pending_bits_reg  <= pending_bits_next;
            pending_count_reg <= pending_count_next;
        end
    end

endmodule

>>> hw/rtl/b64e_queue.sv
module b64e_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  b64e_pkg::job_t  push_job,
    output logic            push_ready,
    input  logic            pop,
    output logic            pop_valid,
    output b64e_pkg::job_t  pop_job
);
    import b64e_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slots_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/b64e_back.sv
module b64e_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    input  b64e_pkg::job_t  job,
    output logic            job_pop,
    b64e_char_if.source     coded
);
    import b64e_pkg::*;

    job_t              job_reg;
    logic              busy_reg;
    logic [1:0]        slot_reg;
    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic              out_last_reg;
    logic              advance;
    logic              finishing;
    logic [SEXTET_W-1:0] sextet;
    logic [2:0]        slot_sum;
    logic [CHAR_W-1:0] char_next;

    assign coded.valid     = out_valid_reg;
    assign coded.out_char  = out_char_reg;
    assign coded.last_char = out_last_reg;

    // Output register frees up when empty or when its item is taken.
    assign advance   = !out_valid_reg || coded.ready;
    assign finishing = busy_reg && advance && (slot_reg == LAST_SLOT);
    assign job_pop   = job_valid && (!busy_reg || finishing);

    always_comb
    begin
        unique case (slot_reg)
            2'd0:    sextet = job_reg.group[23:18];
            2'd1:    sextet = job_reg.group[17:12];
            2'd2:    sextet = job_reg.group[11:6];
            default: sextet = job_reg.group[5:0];
        endcase
        // Trailing slots of a partial group are padding.
        slot_sum  = {1'b0, slot_reg} + {1'b0, job_reg.pads};
        char_next = (slot_sum >= 3'd4) ? PAD_CHAR : sextet_char(sextet);
    end

    always_ff @(posedge clk)
    begin
        if (job_pop) begin
            job_reg <= job;
        end
        if (busy_reg && advance) begin
            out_char_reg <= char_next;
            out_last_reg <= (slot_reg == LAST_SLOT) && job_reg.eom;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                out_valid_reg <= busy_reg;
            end
            if (busy_reg && advance) begin
                slot_reg <= slot_reg + 2'd1;
            end
            if (job_pop) begin
                busy_reg <= 1'b1;
            end else if (finishing) begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule
